FILE: rtl/core/rsti_pkg.sv
// Shared types, constants and the character decoder of the radix string parser.
// Depends on nothing; every other file of the block imports it.
package rsti_pkg;

  // Width of the parsed integer; the result port stays 64 bits wide.
  localparam int unsigned VALUE_BITS = 64;
  localparam int unsigned OUT_W      = 64;
  localparam int unsigned RADIX_W    = 6;
  localparam int unsigned CH_W       = 8;
  localparam int unsigned DIGIT_W    = 6;
  localparam int unsigned PROD_W     = VALUE_BITS + RADIX_W;
  localparam int unsigned SUM_W      = PROD_W + 1;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = RADIX_W;

  localparam logic [RADIX_W-1:0] RADIX_RESET       = RADIX_W'(10);
  localparam logic               SIGNED_MODE_RESET = 1'b1;

  localparam logic [CH_W-1:0] CH_0     = 8'h30;  // '0'
  localparam logic [CH_W-1:0] CH_9     = 8'h39;  // '9'
  localparam logic [CH_W-1:0] CH_LA    = 8'h61;  // 'a'
  localparam logic [CH_W-1:0] CH_LZ    = 8'h7a;  // 'z'
  localparam logic [CH_W-1:0] CH_UA    = 8'h41;  // 'A'
  localparam logic [CH_W-1:0] CH_UZ    = 8'h5a;  // 'Z'
  localparam logic [CH_W-1:0] CH_MINUS = 8'h2d;  // '-'

  localparam logic [VALUE_BITS-1:0] UMAX = {VALUE_BITS{1'b1}};
  localparam logic [VALUE_BITS-1:0] SMAX = UMAX >> 1;
  localparam logic [VALUE_BITS-1:0] SMIN_MAG = SMAX + VALUE_BITS'(1);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX       = 1'b0,
    REG_SIGNED_MODE = 1'b1
  } cfg_reg_e;

  typedef struct packed {
    logic [RADIX_W-1:0] radix;
    logic               signed_mode;
  } cfg_t;

  typedef struct packed {
    logic [VALUE_BITS-1:0] acc;
    logic                  neg;
    logic                  failed;
    logic                  first;
  } parse_state_t;

  typedef struct packed {
    logic               ok;
    logic [DIGIT_W-1:0] val;
  } digit_t;

  function automatic digit_t digit_of(logic [CH_W-1:0] c);
    digit_t r;
    r.ok  = 1'b1;
    r.val = '0;
    if (c >= CH_0 && c <= CH_9) begin
      r.val = DIGIT_W'(c - CH_0);
    end else if (c >= CH_LA && c <= CH_LZ) begin
      r.val = DIGIT_W'(c - CH_LA) + DIGIT_W'(10);
    end else if (c >= CH_UA && c <= CH_UZ) begin
      r.val = DIGIT_W'(c - CH_UA) + DIGIT_W'(10);
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

endpackage

FILE: rtl/core/rsti_if.sv
// Valid/ready channels of the radix string parser: character in, result out,
// configuration write. Depends on rsti_pkg.
interface rsti_in_if import rsti_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;
  logic            last;
  logic            empty_req;
  modport source (output valid, ch, last, empty_req, input ready);
  modport sink   (input valid, ch, last, empty_req, output ready);
endinterface

interface rsti_out_if import rsti_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             success;
  logic [OUT_W-1:0] value;
  modport source (output valid, success, value, input ready);
  modport sink   (input valid, success, value, output ready);
endinterface

interface rsti_cfg_if import rsti_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: rtl/core/radix_string_to_integer.sv
// Radix string parser: one character per beat in, one result per string out.
// A character beat passes the input register; a closing beat then loads the result register that drives out_o.
// Throughput: one character beat per cycle while the result slot is free; the loop is one 64x6 multiply,
// an add and a limit compare on the accumulator in rsti_step.
// Reset: radix 10, signed mode on, parse state cleared, no beat in flight.
// Depends on rsti_pkg, rsti_if, rsti_cfg and rsti_step.
module radix_string_to_integer import rsti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  rsti_in_if.sink     in_i,
  rsti_out_if.source  out_o,
  rsti_cfg_if.sink    cfg_i
);

  cfg_t cfg;

  // Input register: one character beat waiting for the step logic.
  logic            s1_valid_q;
  logic [CH_W-1:0] s1_ch_q;
  logic            s1_last_q;
  logic            s1_empty_q;

  // Parse state carried between the characters of one string.
  parse_state_t state_q, state_d;
  parse_state_t step_state;

  // Result register: magnitude and sign, negated on the way out.
  logic                  out_valid_q, out_valid_d;
  logic                  out_success_q, out_success_d;
  logic                  out_neg_q, out_neg_d;
  logic [VALUE_BITS-1:0] out_mag_q, out_mag_d;

  logic s1_makes_result;
  logic s1_fire;
  logic in_fire;

  parse_state_t clear_state;

  assign clear_state = '{acc: '0, neg: 1'b0, failed: 1'b0, first: 1'b1};

  rsti_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  rsti_step u_step (
    .cfg_i   (cfg),
    .ch_i    (s1_ch_q),
    .last_i  (s1_last_q),
    .state_i (state_q),
    .state_o (step_state)
  );

  // A beat that closes a string may move only when the result slot frees up;
  // any other beat just updates the parse state and never stalls.
  assign s1_makes_result = s1_last_q || s1_empty_q;
  assign s1_fire  = s1_valid_q && (!s1_makes_result || !out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_fire;
  assign in_fire  = in_i.valid && in_i.ready;

  always_comb begin
    state_d       = state_q;
    out_valid_d   = out_valid_q && !out_o.ready;
    out_success_d = out_success_q;
    out_neg_d     = out_neg_q;
    out_mag_d     = out_mag_q;
    if (s1_fire) begin
      if (s1_empty_q) begin
        // Empty string: fail and drop whatever partial parse was running.
        state_d       = clear_state;
        out_valid_d   = 1'b1;
        out_success_d = 1'b0;
        out_neg_d     = 1'b0;
        out_mag_d     = '0;
      end else if (s1_last_q) begin
        state_d       = clear_state;
        out_valid_d   = 1'b1;
        out_success_d = !step_state.failed;
        out_neg_d     = step_state.neg && !step_state.failed;
        out_mag_d     = step_state.failed ? '0 : step_state.acc;
      end else begin
        state_d = step_state;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      state_q     <= '{acc: '0, neg: 1'b0, failed: 1'b0, first: 1'b1};
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: hold until the next accepted beat.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      s1_ch_q    <= in_i.ch;
      s1_last_q  <= in_i.last;
      s1_empty_q <= in_i.empty_req;
    end
    out_success_q <= out_success_d;
    out_neg_q     <= out_neg_d;
    out_mag_q     <= out_mag_d;
  end

  assign out_o.valid   = out_valid_q;
  assign out_o.success = out_success_q;
  assign out_o.value   = out_neg_q ? (OUT_W'(0) - OUT_W'(out_mag_q)) : OUT_W'(out_mag_q);

endmodule

FILE: rtl/core/rsti_cfg.sv
// Configuration registers of the radix string parser (radix, signed mode).
// Depends on rsti_pkg and rsti_cfg_if.
module rsti_cfg import rsti_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsti_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      case (cfg_reg_e'(cfg_i.index))
        REG_RADIX:       cfg_d.radix       = cfg_i.data;
        REG_SIGNED_MODE: cfg_d.signed_mode = cfg_i.data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.radix       <= RADIX_RESET;
      cfg_q.signed_mode <= SIGNED_MODE_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: rtl/core/rsti_step.sv
// One character step: decode the digit or leading minus sign, multiply-accumulate and range check.
// Pure combinational; depends on rsti_pkg.
module rsti_step import rsti_pkg::*; (
  input  cfg_t            cfg_i,
  input  logic [CH_W-1:0] ch_i,
  input  logic            last_i,
  input  parse_state_t    state_i,
  output parse_state_t    state_o
);

  digit_t                digit;
  logic                  minus_sign;
  logic                  bad_digit;
  logic [VALUE_BITS-1:0] limit;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W-1:0]      sum;
  logic                  overflow;

  assign digit      = digit_of(ch_i);
  assign minus_sign = state_i.first && cfg_i.signed_mode && (ch_i == CH_MINUS) && !last_i;
  assign bad_digit  = !digit.ok || (digit.val >= cfg_i.radix);

  // acc * radix + d > limit is the exact form of the divide-based check
  assign limit    = state_i.neg ? SMIN_MAG : (cfg_i.signed_mode ? SMAX : UMAX);
  assign prod     = PROD_W'(state_i.acc) * PROD_W'(cfg_i.radix);
  assign sum      = SUM_W'(prod) + SUM_W'(digit.val);
  assign overflow = sum > SUM_W'(limit);

  always_comb begin
    state_o       = state_i;
    state_o.first = 1'b0;
    if (!state_i.failed) begin
      if (minus_sign) begin
        state_o.neg = 1'b1;
      end else if (bad_digit || overflow) begin
        state_o.failed = 1'b1;
      end else begin
        state_o.acc = sum[VALUE_BITS-1:0];
      end
    end
  end

endmodule
